/* design/tfs_pkg.sv */
// ----------------------------------------------------------------------------
// tfs_pkg: shared types and constants for the text field splitter
// Parse phase codes, config and result bundles, character constants and
// the set membership helper.
// ----------------------------------------------------------------------------
package tfs_pkg;

  // Largest field the emission limit may reach
  localparam int FIELD_CAPACITY = 256;

  // Slot counts of the register layout
  localparam int SPACE_SLOTS_DEF = 2;
  localparam int QUOTE_SLOTS_DEF = 4;
  localparam int TERM_SLOTS_DEF  = 8;
  localparam int SPACE_BYTES     = 2;
  localparam int QUOTE_BYTES     = 4;
  localparam int TERM_BYTES      = 8;

  // Register reset values
  localparam logic [63:0] SPACE_RESET   = 64'd2336;
  localparam logic [63:0] QUOTE_RESET   = 64'd10018;
  localparam logic [63:0] TERM_RESET    = 64'd2336;
  localparam logic [8:0]  MAX_LEN_RESET = 9'd24;

  // Config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd3;

  // Special characters
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BANG = 8'h21;

  // Result kinds
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam int OUT_TDATA_W = 48;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_LINE    = 5'b00001,
    PH_COMMENT = 5'b00010,
    PH_LEAD    = 5'b00100,
    PH_FIELD   = 5'b01000,
    PH_QUOTED  = 5'b10000
  } tfs_phase_t;

  // Config as seen by the parser, unused slots zero
  typedef struct packed {
    logic [63:0] space;
    logic [63:0] quote;
    logic [63:0] term;
    logic [8:0]  max_len;
  } tfs_cfg_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_char;
    logic [7:0]  char_position;
    logic [15:0] field_length;
    logic [7:0]  terminator;
    logic        line_ended;
    logic        input_ended;
    logic        truncated;
  } tfs_result_t;

  // Byte matches a nonzero slot; a zero byte matches every set
  function automatic logic in_set(input logic [7:0] c, input logic [63:0] set);
    logic hit;
    hit = (c == 8'h00);
    for (int i = 0; i < 8; i++) begin
      if (set[8*i +: 8] != 8'h00 && set[8*i +: 8] == c) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

/* design/text_field_splitter_unit.sv */
// An accepted request is held in the input register and parsed from there;
// its result (if any) goes to the result register and then onto out_tvalid.
// Throughput: one byte per cycle while out_tready does not stall the result
// register, set by the parse step between the input and result registers.
// Reset (rst_n low, synchronous) returns the parser to line start with
// cleared counters, empties both registers and restores register defaults.
// ----------------------------------------------------------------------------
// text_field_splitter_unit: streaming CSV-style field tokenizer
// Splits a byte stream into field characters and end-of-field reports,
// driven by configurable space, quote and terminator sets.
// ----------------------------------------------------------------------------
module text_field_splitter_unit #(
  parameter int TERM_SLOTS  = tfs_pkg::TERM_SLOTS_DEF,
  parameter int QUOTE_SLOTS = tfs_pkg::QUOTE_SLOTS_DEF,
  parameter int SPACE_SLOTS = tfs_pkg::SPACE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] in_char
  input  logic                            in_tuser,   // [0] end_of_input
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] out_char, [15:8] char_position, [31:16] field_length,
  // [39:32] terminator, [40] line_ended, [41] input_ended, [42] truncated
  output logic [tfs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // [0] kind
  // config writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);
  import tfs_pkg::*;

  localparam int SP_N = (SPACE_SLOTS < SPACE_BYTES) ? SPACE_SLOTS : SPACE_BYTES;
  localparam int QT_N = (QUOTE_SLOTS < QUOTE_BYTES) ? QUOTE_SLOTS : QUOTE_BYTES;
  localparam int TM_N = (TERM_SLOTS  < TERM_BYTES)  ? TERM_SLOTS  : TERM_BYTES;

  logic [SP_N*8-1:0] space_r;
  logic [QT_N*8-1:0] quote_r;
  logic [TM_N*8-1:0] term_r;
  logic [8:0]        max_len_r;
  tfs_cfg_t          cfg;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_eoi_r;
  logic        out_free;
  logic        step;
  logic        res_valid;
  tfs_result_t res;
  logic        out_valid_r;
  tfs_result_t res_r;

  // Config registers, only the slots in use are kept
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r   <= SPACE_RESET[SP_N*8-1:0];
      quote_r   <= QUOTE_RESET[QT_N*8-1:0];
      term_r    <= TERM_RESET[TM_N*8-1:0];
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPACE:   space_r   <= cfg_data[SP_N*8-1:0];
        CFG_QUOTE:   quote_r   <= cfg_data[QT_N*8-1:0];
        CFG_TERM:    term_r    <= cfg_data[TM_N*8-1:0];
        CFG_MAX_LEN: max_len_r <= cfg_data[8:0];
        default:     max_len_r <= max_len_r;
      endcase
    end
  end

  assign cfg.space   = 64'(space_r);
  assign cfg.quote   = 64'(quote_r);
  assign cfg.term    = 64'(term_r);
  assign cfg.max_len = max_len_r;

  // Handshake: stage 1 moves on when the result register can take it
  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_eoi_r  <= in_tuser;
    end
  end

  // Parse step
  tfs_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .c         (s1_char_r),
    .eoi       (s1_eoi_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {5'b0, res_r.truncated, res_r.input_ended, res_r.line_ended,
                       res_r.terminator, res_r.field_length, res_r.char_position,
                       res_r.out_char};

  // A character is only emitted below the length limit
  a_char_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == KIND_CHAR |-> {1'b0, res_r.char_position} < max_len_r)
    else $error("character emitted past the length limit");

  // End-of-input report always closes the line with a zero terminator
  a_eoi_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.input_ended |->
      res_r.kind == KIND_REPORT && res_r.line_ended && res_r.terminator == 8'h00)
    else $error("malformed end-of-input report");

  // A full input register with a stalled result blocks new requests
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready && !step)
    else $error("request taken while the result register is stalled");

endmodule

/* design/tfs_parse_core.sv */
// ----------------------------------------------------------------------------
// tfs_parse_core: field parser state and single-step logic
// Holds phase, open quote and field counters; on each step classifies one
// byte and produces at most one result.
// ----------------------------------------------------------------------------
module tfs_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          c,
  input  logic                eoi,
  input  tfs_pkg::tfs_cfg_t   cfg,
  output logic                res_valid,
  output tfs_pkg::tfs_result_t res
);
  import tfs_pkg::*;

  tfs_phase_t  phase_r, phase_nxt;
  logic [7:0]  oq_r, oq_nxt;
  logic [15:0] raw_r, raw_nxt;
  logic [15:0] trim_r, trim_nxt;

  logic        is_sp, is_qt, is_tm;
  logic [8:0]  lim;
  logic [15:0] raw_inc;
  logic        do_fc;
  logic        want_rep, rep_line, rep_eoi;
  logic [7:0]  rep_term;
  logic        want_data, data_counts;

  // Character classes
  assign is_sp = in_set(c, cfg.space);
  assign is_qt = in_set(c, cfg.quote);
  assign is_tm = in_set(c, cfg.term);

  // Emission limit: smaller of register and capacity
  always_comb begin
    lim = cfg.max_len;
    if (FIELD_CAPACITY < 512 && 17'(cfg.max_len) > 17'(FIELD_CAPACITY)) begin
      lim = 9'(FIELD_CAPACITY);
    end
  end

  assign raw_inc = (raw_r == 16'hFFFF) ? raw_r : raw_r + 16'd1;

  // Phase decisions
  always_comb begin
    phase_nxt   = phase_r;
    oq_nxt      = oq_r;
    do_fc       = 1'b0;
    want_rep    = 1'b0;
    rep_term    = 8'h00;
    rep_line    = 1'b0;
    rep_eoi     = 1'b0;
    want_data   = 1'b0;
    data_counts = 1'b0;

    if (eoi) begin
      phase_nxt = PH_LINE;
      want_rep  = 1'b1;
      rep_line  = 1'b1;
      rep_eoi   = 1'b1;
    end else begin
      unique case (phase_r)
        PH_COMMENT: begin
          if (c == CH_NL) phase_nxt = PH_LINE;
        end
        PH_LEAD: begin
          if (!is_sp) do_fc = 1'b1;
        end
        PH_FIELD: begin
          do_fc = 1'b1;
        end
        PH_QUOTED: begin
          if (c == CH_NL) begin
            phase_nxt = PH_LINE;
            want_rep  = 1'b1;
            rep_term  = c;
            rep_line  = 1'b1;
          end else if (c == oq_r) begin
            oq_nxt    = 8'h00;
            phase_nxt = PH_FIELD;
          end else begin
            want_data   = 1'b1;
            data_counts = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_LINE;
          if (is_sp) begin
            phase_nxt = PH_LINE;
          end else if (c == CH_HASH || c == CH_BANG) begin
            phase_nxt = PH_COMMENT;
          end else begin
            do_fc = 1'b1;
          end
        end
      endcase

      // Ordinary field byte
      if (do_fc) begin
        if (c == CH_NL) begin
          phase_nxt = PH_LINE;
          want_rep  = 1'b1;
          rep_term  = c;
          rep_line  = 1'b1;
        end else if (is_qt) begin
          oq_nxt    = c;
          phase_nxt = PH_QUOTED;
        end else if (is_tm) begin
          phase_nxt = PH_LEAD;
          want_rep  = 1'b1;
          rep_term  = c;
        end else begin
          phase_nxt   = PH_FIELD;
          want_data   = 1'b1;
          data_counts = !is_sp;
        end
      end
    end
  end

  // Result and counter update
  always_comb begin
    raw_nxt   = raw_r;
    trim_nxt  = trim_r;
    res_valid = 1'b0;
    res       = '0;
    if (want_rep) begin
      res_valid        = 1'b1;
      res.kind         = KIND_REPORT;
      res.field_length = trim_r;
      res.terminator   = rep_term;
      res.line_ended   = rep_line;
      res.input_ended  = rep_eoi;
      res.truncated    = raw_r > {7'b0, lim};
      raw_nxt          = 16'd0;
      trim_nxt         = 16'd0;
    end else if (want_data) begin
      if (raw_r < {7'b0, lim}) begin
        res_valid         = 1'b1;
        res.kind          = KIND_CHAR;
        res.out_char      = c;
        res.char_position = raw_r[7:0];
      end
      raw_nxt = raw_inc;
      if (data_counts) trim_nxt = raw_inc;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE;
      oq_r    <= 8'h00;
      raw_r   <= 16'd0;
      trim_r  <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      oq_r    <= want_rep ? 8'h00 : oq_nxt;
      raw_r   <= raw_nxt;
      trim_r  <= trim_nxt;
    end
  end

endmodule
